// ----- sv/gbiq_pkg.sv -----
package gbiq_pkg;

   localparam int NUM_PINS_DEF    = 16;
   localparam int QUEUE_DEPTH_DEF = 16;

   localparam int CMD_W    = 3;
   localparam int PIN_W    = 4;
   localparam int VALUE_W  = 16;
   localparam int STATUS_W = 3;
   localparam int LEVEL_W  = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_TOGGLE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_ANALOG = 3'd3;
   localparam logic [CMD_W-1:0] CMD_POP    = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_PIN    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_WRONG_MODE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_VALUE  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_ANALOG = 3'd4;
   localparam logic [STATUS_W-1:0] ST_Q_EMPTY    = 3'd5;

   localparam logic [1:0] MODE_UNUSED = 2'd0;
   localparam logic [1:0] MODE_INPUT  = 2'd1;
   localparam logic [1:0] MODE_OUTPUT = 2'd2;
   localparam logic [1:0] MODE_PULLUP = 2'd3;

   localparam logic [2:0] IRQ_NONE    = 3'd0;
   localparam logic [2:0] IRQ_LOW     = 3'd1;
   localparam logic [2:0] IRQ_RISING  = 3'd2;
   localparam logic [2:0] IRQ_FALLING = 3'd3;
   localparam logic [2:0] IRQ_CHANGE  = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_LOWEST     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGHEST    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PIN_MODES  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ANALOG_MSK = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IRQ_MSK    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_IRQ_MODES  = 3'd5;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

   typedef struct packed {
      logic [3:0]  lowest_pin;
      logic [3:0]  highest_pin;
      logic [31:0] pin_modes;
      logic [15:0] analog_mask;
      logic [15:0] irq_mask;
      logic [47:0] irq_modes;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      lowest_pin:  4'd0,
      highest_pin: 4'd10,
      pin_modes:   32'h0,
      analog_mask: 16'hFFFF,
      irq_mask:    16'h000C,
      irq_modes:   48'h0
   };

endpackage

// ----- sv/gbiq_if.sv -----
interface gbiq_req_if;
   logic                              valid;
   logic                              ready;
   logic [gbiq_pkg::CMD_W-1:0]        cmd;
   logic [gbiq_pkg::PIN_W-1:0]        pin;
   logic signed [gbiq_pkg::VALUE_W-1:0] value;

   modport source (output valid, output cmd, output pin, output value, input ready);
   modport sink   (input valid, input cmd, input pin, input value, output ready);
endinterface

interface gbiq_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [gbiq_pkg::STATUS_W-1:0]   status;
   logic [gbiq_pkg::LEVEL_W-1:0]    read_value;
   logic [gbiq_pkg::PIN_W-1:0]      irq_pin;
   logic                            irq_queued;
   logic                            irq_dropped;

   modport source (output valid, output status, output read_value, output irq_pin,
                   output irq_queued, output irq_dropped, input ready);
   modport sink   (input valid, input status, input read_value, input irq_pin,
                   input irq_queued, input irq_dropped, output ready);
endinterface

// ----- sv/gbiq_ram.sv -----
module gbiq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/gbiq_csr.sv -----
module gbiq_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [gbiq_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gbiq_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output gbiq_pkg::cfg_type                   cfg
);

   gbiq_pkg::cfg_type cfg_ff;
   gbiq_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            gbiq_pkg::CSR_LOWEST:     cfg_in.lowest_pin  = csr_wdata[3:0];
            gbiq_pkg::CSR_HIGHEST:    cfg_in.highest_pin = csr_wdata[3:0];
            gbiq_pkg::CSR_PIN_MODES:  cfg_in.pin_modes   = csr_wdata[31:0];
            gbiq_pkg::CSR_ANALOG_MSK: cfg_in.analog_mask = csr_wdata[15:0];
            gbiq_pkg::CSR_IRQ_MSK:    cfg_in.irq_mask    = csr_wdata[15:0];
            gbiq_pkg::CSR_IRQ_MODES:  cfg_in.irq_modes   = csr_wdata[47:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= gbiq_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- sv/gbiq_exec.sv -----
module gbiq_exec #(
   parameter int NUM_PINS    = gbiq_pkg::NUM_PINS_DEF,
   parameter int QUEUE_DEPTH = gbiq_pkg::QUEUE_DEPTH_DEF,
   localparam int PIN_AW     = $clog2(NUM_PINS),
   localparam int PIN_SLOTS  = 2 ** PIN_AW,
   localparam int Q_AW       = $clog2(QUEUE_DEPTH),
   localparam int Q_CW       = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  gbiq_pkg::cfg_type                  cfg,
   gbiq_req_if.sink                           req_chan,
   gbiq_rsp_if.source                         rsp_chan,
   output logic                               lvl_we,
   output logic [PIN_AW-1:0]                  lvl_waddr,
   output logic [gbiq_pkg::LEVEL_W-1:0]       lvl_wdata,
   output logic                               lvl_re,
   output logic [PIN_AW-1:0]                  lvl_raddr,
   input  logic [gbiq_pkg::LEVEL_W-1:0]       lvl_rdata,
   output logic                               q_we,
   output logic [Q_AW-1:0]                    q_waddr,
   output logic [gbiq_pkg::PIN_W-1:0]         q_wdata,
   output logic                               q_re,
   output logic [Q_AW-1:0]                    q_raddr,
   input  logic [gbiq_pkg::PIN_W-1:0]         q_rdata
);

   localparam int W8 = gbiq_pkg::LEVEL_W;

   // input stage
   logic                                s1_valid_ff, s1_valid_in;
   logic [gbiq_pkg::CMD_W-1:0]          s1_cmd_ff;
   logic [gbiq_pkg::PIN_W-1:0]          s1_pin_ff;
   logic signed [gbiq_pkg::VALUE_W-1:0] s1_value_ff;
   logic                                s1_byp_ff, s1_byp_in;
   logic [W8-1:0]                       s1_byp_data_ff;
   logic                                s1_lvl_vld_ff;

   // result stage
   logic                                r_valid_ff, r_valid_in;
   logic [gbiq_pkg::STATUS_W-1:0]       r_status_ff;
   logic [W8-1:0]                       r_read_ff;
   logic                                r_pop_ok_ff;
   logic                                r_queued_ff;
   logic                                r_dropped_ff;

   // bank and queue state
   logic [PIN_SLOTS-1:0]                lvl_vld_ff, lvl_vld_in;
   logic [Q_AW-1:0]                     head_ff, head_in;
   logic [Q_AW-1:0]                     tail_ff, tail_in;
   logic [Q_CW-1:0]                     count_ff, count_in;

   logic                                proc;
   logic                                accept;
   logic [W8-1:0]                       level;
   logic                                in_range;
   logic [1:0]                          mode;
   logic [2:0]                          irq_mode;
   logic                                is_input;
   logic [gbiq_pkg::STATUS_W-1:0]       status;
   logic [W8-1:0]                       rd;
   logic                                wr_en;
   logic [W8-1:0]                       wr_data;
   logic                                set_en;
   logic                                changed;
   logic                                fire;
   logic                                push;
   logic                                pop;
   logic                                dropped;

   assign proc   = s1_valid_ff && (!r_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || proc;
   assign accept = req_chan.valid && req_chan.ready;

   assign level = s1_byp_ff ? s1_byp_data_ff :
                  (s1_lvl_vld_ff ? lvl_rdata : '0);
   assign in_range = (s1_pin_ff >= cfg.lowest_pin) && (s1_pin_ff <= cfg.highest_pin) &&
                     (int'(s1_pin_ff) < NUM_PINS);
   assign mode     = cfg.pin_modes[2*s1_pin_ff +: 2];
   assign irq_mode = cfg.irq_modes[3*s1_pin_ff +: 3];
   assign is_input = (mode == gbiq_pkg::MODE_INPUT) || (mode == gbiq_pkg::MODE_PULLUP);

   always_comb begin
      status  = gbiq_pkg::ST_OK;
      rd      = '0;
      wr_en   = 1'b0;
      wr_data = '0;
      set_en  = 1'b0;
      pop     = 1'b0;
      if (s1_cmd_ff == gbiq_pkg::CMD_POP) begin
         if (count_ff == '0) begin
            status = gbiq_pkg::ST_Q_EMPTY;
         end else begin
            pop = 1'b1;
         end
      end else if (s1_cmd_ff > gbiq_pkg::CMD_POP) begin
         status = gbiq_pkg::ST_BAD_VALUE;
      end else if (!in_range) begin
         status = gbiq_pkg::ST_BAD_PIN;
      end else begin
         case (s1_cmd_ff)
            gbiq_pkg::CMD_WRITE: begin
               if (mode != gbiq_pkg::MODE_OUTPUT) begin
                  status = gbiq_pkg::ST_WRONG_MODE;
               end else if (s1_value_ff != 16'sd0 && s1_value_ff != 16'sd1) begin
                  status = gbiq_pkg::ST_BAD_VALUE;
               end else begin
                  wr_en   = 1'b1;
                  set_en  = 1'b1;
                  wr_data = {{(W8-1){1'b0}}, s1_value_ff[0]};
               end
            end
            gbiq_pkg::CMD_TOGGLE: begin
               if (!is_input) begin
                  status = gbiq_pkg::ST_WRONG_MODE;
               end else begin
                  wr_en   = 1'b1;
                  set_en  = 1'b1;
                  wr_data = {{(W8-1){1'b0}}, (level == '0)};
               end
            end
            gbiq_pkg::CMD_READ: begin
               if (!is_input) begin
                  status = gbiq_pkg::ST_WRONG_MODE;
               end else begin
                  rd = level;
               end
            end
            gbiq_pkg::CMD_ANALOG: begin
               if (mode != gbiq_pkg::MODE_OUTPUT) begin
                  status = gbiq_pkg::ST_WRONG_MODE;
               end else if (!cfg.analog_mask[s1_pin_ff]) begin
                  status = gbiq_pkg::ST_NOT_ANALOG;
               end else begin
                  wr_en = 1'b1;
                  if (s1_value_ff < 16'sd0) begin
                     wr_data = '0;
                  end else if (s1_value_ff > 16'sd255) begin
                     wr_data = gbiq_pkg::LEVEL_MAX;
                  end else begin
                     wr_data = s1_value_ff[W8-1:0];
                  end
               end
            end
            default: status = gbiq_pkg::ST_BAD_VALUE;
         endcase
      end
   end

   always_comb begin
      changed = (wr_data != level);
      case (irq_mode)
         gbiq_pkg::IRQ_LOW:     fire = (wr_data == '0);
         gbiq_pkg::IRQ_RISING:  fire = changed && (wr_data == 8'd1);
         gbiq_pkg::IRQ_FALLING: fire = changed && (wr_data == '0);
         gbiq_pkg::IRQ_CHANGE:  fire = changed;
         default:               fire = 1'b0;
      endcase
      fire    = fire && set_en && cfg.irq_mask[s1_pin_ff];
      dropped = fire && (count_ff == Q_CW'(QUEUE_DEPTH));
      push    = fire && !dropped;
   end

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      lvl_vld_in = lvl_vld_ff;
      if (proc && pop) begin
         head_in  = (head_ff == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
      if (proc && push) begin
         tail_in  = (tail_ff == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end
      if (proc && wr_en) begin
         lvl_vld_in[PIN_AW'(s1_pin_ff)] = 1'b1;
      end
   end

   assign lvl_we    = proc && wr_en;
   assign lvl_waddr = PIN_AW'(s1_pin_ff);
   assign lvl_wdata = wr_data;
   assign lvl_re    = accept;
   assign lvl_raddr = PIN_AW'(req_chan.pin);

   assign q_we    = proc && push;
   assign q_waddr = tail_ff;
   assign q_wdata = s1_pin_ff;
   assign q_re    = proc && pop;
   assign q_raddr = head_ff;

   assign s1_valid_in = accept ? 1'b1 : (proc ? 1'b0 : s1_valid_ff);
   assign s1_byp_in   = proc && wr_en && (s1_pin_ff == req_chan.pin);
   assign r_valid_in  = proc ? 1'b1 : (rsp_chan.ready ? 1'b0 : r_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         r_valid_ff  <= 1'b0;
         lvl_vld_ff  <= '0;
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         r_valid_ff  <= r_valid_in;
         lvl_vld_ff  <= lvl_vld_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff      <= req_chan.cmd;
         s1_pin_ff      <= req_chan.pin;
         s1_value_ff    <= req_chan.value;
         s1_byp_ff      <= s1_byp_in;
         s1_byp_data_ff <= wr_data;
         s1_lvl_vld_ff  <= lvl_vld_ff[PIN_AW'(req_chan.pin)];
      end
      if (proc) begin
         r_status_ff  <= status;
         r_read_ff    <= rd;
         r_pop_ok_ff  <= pop;
         r_queued_ff  <= push;
         r_dropped_ff <= dropped;
      end
   end

   assign rsp_chan.valid       = r_valid_ff;
   assign rsp_chan.status      = r_status_ff;
   assign rsp_chan.read_value  = r_read_ff;
   assign rsp_chan.irq_pin     = r_pop_ok_ff ? q_rdata : '0;
   assign rsp_chan.irq_queued  = r_queued_ff;
   assign rsp_chan.irq_dropped = r_dropped_ff;

endmodule

// ----- sv/gpio_bank_with_interrupt_queue_unit.sv -----
// channel | dir | handshake    | payload
// req_    | in  | valid/ready  | cmd[2:0], pin[3:0], value[15:0] signed
// rsp_    | out | valid/ready  | status[2:0], read_value[7:0], irq_pin[3:0],
//         |     |              | irq_queued, irq_dropped
// csr_    | in  | write enable | csr_index[2:0], csr_wdata[47:0]
//
// One transaction per cycle sustained while responses are taken; a request passes the input
// register at accept, then the result register once the result stage is free.
// Pin levels sit in a RAM read at accept time, with a bypass from the access ahead.
// Reset clears the pin-valid bits, queue pointers and stage valids, and loads CFG_RESET.
// A stalled response holds; the input register keeps accepting until it is also full.
module gpio_bank_with_interrupt_queue_unit #(
   parameter int NUM_PINS    = gbiq_pkg::NUM_PINS_DEF,
   parameter int QUEUE_DEPTH = gbiq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   gbiq_req_if.sink                        req_chan,
   gbiq_rsp_if.source                      rsp_chan,
   input  logic                            csr_we,
   input  logic [gbiq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gbiq_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int PIN_AW    = $clog2(NUM_PINS);
   localparam int PIN_SLOTS = 2 ** PIN_AW;
   localparam int Q_AW      = $clog2(QUEUE_DEPTH);

   gbiq_pkg::cfg_type                cfg;
   logic                             lvl_we, lvl_re;
   logic [PIN_AW-1:0]                lvl_waddr, lvl_raddr;
   logic [gbiq_pkg::LEVEL_W-1:0]     lvl_wdata, lvl_rdata;
   logic                             q_we, q_re;
   logic [Q_AW-1:0]                  q_waddr, q_raddr;
   logic [gbiq_pkg::PIN_W-1:0]       q_wdata, q_rdata;

   gbiq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gbiq_ram #(.WIDTH(gbiq_pkg::LEVEL_W), .DEPTH(PIN_SLOTS)) u_level_ram (
      .clock (clock),
      .we    (lvl_we),
      .waddr (lvl_waddr),
      .wdata (lvl_wdata),
      .re    (lvl_re),
      .raddr (lvl_raddr),
      .rdata (lvl_rdata)
   );

   gbiq_ram #(.WIDTH(gbiq_pkg::PIN_W), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
      .clock (clock),
      .we    (q_we),
      .waddr (q_waddr),
      .wdata (q_wdata),
      .re    (q_re),
      .raddr (q_raddr),
      .rdata (q_rdata)
   );

   gbiq_exec #(.NUM_PINS(NUM_PINS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_exec (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .lvl_we    (lvl_we),
      .lvl_waddr (lvl_waddr),
      .lvl_wdata (lvl_wdata),
      .lvl_re    (lvl_re),
      .lvl_raddr (lvl_raddr),
      .lvl_rdata (lvl_rdata),
      .q_we      (q_we),
      .q_waddr   (q_waddr),
      .q_wdata   (q_wdata),
      .q_re      (q_re),
      .q_raddr   (q_raddr),
      .q_rdata   (q_rdata)
   );

endmodule

// ----- sv/gbiq_checker.sv -----
module gbiq_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [gbiq_pkg::STATUS_W-1:0]     rsp_status,
   input logic [gbiq_pkg::LEVEL_W-1:0]      rsp_read_value,
   input logic [gbiq_pkg::PIN_W-1:0]        rsp_irq_pin,
   input logic                              rsp_irq_queued,
   input logic                              rsp_irq_dropped
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped or changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != gbiq_pkg::ST_OK |->
         rsp_read_value == '0 && rsp_irq_pin == '0 && !rsp_irq_queued && !rsp_irq_dropped)
      else $error("failed access carries data or interrupt flags");

   a_irq_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_irq_queued || rsp_irq_dropped) |->
         !(rsp_irq_queued && rsp_irq_dropped) && rsp_read_value == '0 && rsp_irq_pin == '0)
      else $error("interrupt flags mixed with read or pop data");

endmodule

bind gpio_bank_with_interrupt_queue_unit gbiq_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_read_value  (rsp_chan.read_value),
   .rsp_irq_pin     (rsp_chan.irq_pin),
   .rsp_irq_queued  (rsp_chan.irq_queued),
   .rsp_irq_dropped (rsp_chan.irq_dropped)
);
